/* rtl/core/tgapsd_pkg.sv */
`default_nettype none

package tgapsd_pkg;

  typedef enum logic [1:0] {
    FMT_555  = 2'd0,
    FMT_BGR  = 2'd1,
    FMT_BGRA = 2'd2,
    FMT_RSVD = 2'd3
  } pix_fmt_e;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_RLE    = 2'd1,
    REG_TOTAL  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  localparam logic [1:0]  FMT_RESET   = 2'd1;
  localparam logic        RLE_RESET   = 1'b0;
  localparam logic [31:0] TOTAL_RESET = 32'd1;

  typedef struct packed {
    pix_fmt_e    pixel_format;
    logic        rle_enable;
    logic [31:0] pixel_total;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_end;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/tga_pixel_stream_decoder_top.sv */
// TGA pixel stream decoder. Payload bytes enter on the input channel
// (in_valid_i, in_ready_o, data_byte_i) and decoded pixels leave on the
// output channel (out_valid_o, out_ready_i and the color fields).
// Format, run-length mode and pixel total are set through the APB port
// while the block is idle; the user must keep to this, as the block does
// not enforce it. A write to any of these three registers restarts
// decoding. A byte is captured in the input register when accepted and is
// decoded from it; its pixel enters the output register when the input
// register advances. One byte is taken every cycle while the receiver
// does not stall; a pixel needs as many bytes as its format has, and each
// packet header takes one more. Bytes that complete no pixel produce no
// result, but the first byte under an unsupported format yields an error
// result. Reset empties both registers and restores 24-bit BGR, no
// run-length coding and a total of one pixel. When the receiver stalls,
// the result is held and an empty input register still takes one more
// byte; after that in_ready_o drops until the output register drains.
`default_nettype none

module tga_pixel_stream_decoder_top
  import tgapsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  red_o,
  output logic      [7:0]  green_o,
  output logic      [7:0]  blue_o,
  output logic      [7:0]  alpha_o,
  output logic      [7:0]  repeat_count_o,
  output logic             image_end_o,
  output logic             status_o
);

  cfg_t       cfg;
  logic       clear;
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       adv;
  logic       emit;
  result_t    res_dec;
  result_t    res_out;

  assign adv        = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  tgapsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  tgapsd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .clear_i (clear),
    .step_i  (adv),
    .byte_i  (byte_q),
    .emit_o  (emit),
    .res_o   (res_dec)
  );

  tgapsd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .emit_i      (emit),
    .res_i       (res_dec),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign red_o          = res_out.red;
  assign green_o        = res_out.green;
  assign blue_o         = res_out.blue;
  assign alpha_o        = res_out.alpha;
  assign repeat_count_o = res_out.repeat_count;
  assign image_end_o    = res_out.image_end;
  assign status_o       = res_out.status;

endmodule

`default_nettype wire

/* rtl/core/tgapsd_cfg.sv */
`default_nettype none

module tgapsd_cfg
  import tgapsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o,
  output logic             clear_o
);

  cfg_t     cfg_q, cfg_d;
  logic     clear_q, clear_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d   = cfg_q;
    clear_d = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_FORMAT: begin
          cfg_d.pixel_format = pix_fmt_e'(pwdata[1:0]);
          clear_d            = 1'b1;
        end
        REG_RLE: begin
          cfg_d.rle_enable = pwdata[0];
          clear_d          = 1'b1;
        end
        REG_TOTAL: begin
          cfg_d.pixel_total = pwdata;
          clear_d           = 1'b1;
        end
        default: clear_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FORMAT: prdata = {30'd0, cfg_q.pixel_format};
      REG_RLE:    prdata = {31'd0, cfg_q.rle_enable};
      REG_TOTAL:  prdata = cfg_q.pixel_total;
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format <= pix_fmt_e'(FMT_RESET);
      cfg_q.rle_enable   <= RLE_RESET;
      cfg_q.pixel_total  <= TOTAL_RESET;
      clear_q            <= 1'b0;
    end else begin
      cfg_q   <= cfg_d;
      clear_q <= clear_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign clear_o = clear_q;

endmodule

`default_nettype wire

/* rtl/core/tgapsd_decode.sv */
`default_nettype none

module tgapsd_decode
  import tgapsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       clear_i,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            emit_o,
  output result_t         res_o
);

  logic        exp_hdr_q, exp_hdr_d;
  logic [7:0]  run_left_q, run_left_d;
  logic        run_rep_q, run_rep_d;
  logic [1:0]  slot_q, slot_d;
  logic [23:0] pix_q, pix_d;
  logic [31:0] emitted_q, emitted_d;
  logic        finished_q, finished_d;
  logic        err_q, err_d;

  logic        fmt_err;
  logic        done;
  logic [31:0] remaining;
  logic [7:0]  count;
  logic [23:0] merged;
  logic [7:0]  alpha;
  logic        last;
  logic [7:0]  rep;
  logic [7:0]  run_next;

  assign fmt_err = (cfg_i.pixel_format == FMT_RSVD) ||
                   ((cfg_i.pixel_format == FMT_555) && cfg_i.rle_enable);
  assign done      = finished_q || (emitted_q >= cfg_i.pixel_total);
  assign remaining = cfg_i.pixel_total - emitted_q;
  assign count     = {1'b0, byte_i[6:0]} + 8'd1;

  always_comb begin
    merged = pix_q;
    alpha  = 8'd0;
    case (slot_q)
      2'd0:    merged[7:0]   = byte_i;
      2'd1:    merged[15:8]  = byte_i;
      2'd2:    merged[23:16] = byte_i;
      default: alpha         = byte_i;
    endcase
  end

  always_comb begin
    case (cfg_i.pixel_format)
      FMT_555: last = (slot_q == 2'd1);
      FMT_BGR: last = (slot_q == 2'd2);
      default: last = (slot_q == 2'd3);
    endcase
  end

  always_comb begin
    exp_hdr_d  = exp_hdr_q;
    run_left_d = run_left_q;
    run_rep_d  = run_rep_q;
    slot_d     = slot_q;
    pix_d      = pix_q;
    emitted_d  = emitted_q;
    finished_d = finished_q;
    err_d      = err_q;
    emit_o     = 1'b0;
    res_o      = '0;
    rep        = 8'd1;
    run_next   = run_left_q;
    if (clear_i) begin
      exp_hdr_d  = cfg_i.rle_enable;
      run_left_d = 8'd0;
      run_rep_d  = 1'b0;
      slot_d     = 2'd0;
      pix_d      = 24'd0;
      emitted_d  = 32'd0;
      finished_d = 1'b0;
      err_d      = 1'b0;
    end else if (step_i) begin
      if (fmt_err) begin
        if (!err_q) begin
          err_d        = 1'b1;
          emit_o       = 1'b1;
          res_o.status = 1'b1;
        end
      end else if (done) begin
        finished_d = 1'b1;
      end else if (cfg_i.rle_enable && (exp_hdr_q || (run_left_q == 8'd0))) begin
        run_rep_d  = byte_i[7];
        run_left_d = ({24'd0, count} > remaining) ? remaining[7:0] : count;
        exp_hdr_d  = 1'b0;
        slot_d     = 2'd0;
        pix_d      = 24'd0;
      end else if (!last) begin
        slot_d = slot_q + 2'd1;
        pix_d  = merged;
      end else begin
        slot_d = 2'd0;
        pix_d  = 24'd0;
        if (cfg_i.pixel_format == FMT_555) begin
          res_o.blue  = {merged[4:0], 3'b000};
          res_o.green = {merged[9:5], 3'b000};
          res_o.red   = {merged[14:10], 3'b000};
        end else begin
          res_o.blue  = merged[7:0];
          res_o.green = merged[15:8];
          res_o.red   = merged[23:16];
          res_o.alpha = (cfg_i.pixel_format == FMT_BGRA) ? alpha : 8'd0;
        end
        if (cfg_i.rle_enable) begin
          if (run_rep_q) begin
            rep      = run_left_q;
            run_next = 8'd0;
          end else begin
            run_next = run_left_q - 8'd1;
          end
          run_left_d = run_next;
          if (run_next == 8'd0) begin
            exp_hdr_d = 1'b1;
          end
        end
        emitted_d          = emitted_q + {24'd0, rep};
        res_o.repeat_count = rep;
        res_o.image_end    = (emitted_d >= cfg_i.pixel_total);
        if (res_o.image_end) begin
          finished_d = 1'b1;
        end
        emit_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_hdr_q  <= RLE_RESET;
      run_left_q <= 8'd0;
      run_rep_q  <= 1'b0;
      slot_q     <= 2'd0;
      pix_q      <= 24'd0;
      emitted_q  <= 32'd0;
      finished_q <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      exp_hdr_q  <= exp_hdr_d;
      run_left_q <= run_left_d;
      run_rep_q  <= run_rep_d;
      slot_q     <= slot_d;
      pix_q      <= pix_d;
      emitted_q  <= emitted_d;
      finished_q <= finished_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tgapsd_out_stage.sv */
`default_nettype none

module tgapsd_out_stage
  import tgapsd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    adv_i,
  input  wire logic    emit_i,
  input  wire result_t res_i,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (!valid_q || out_ready_i) begin
      valid_d = adv_i && emit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* rtl/core/tgapsd_checker.sv */
`default_nettype none

module tgapsd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_o,
  input wire logic [7:0] green_o,
  input wire logic [7:0] blue_o,
  input wire logic [7:0] alpha_o,
  input wire logic [7:0] repeat_count_o,
  input wire logic       image_end_o,
  input wire logic       status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) &&
      $stable(blue_o) && $stable(alpha_o) && $stable(repeat_count_o) &&
      $stable(image_end_o) && $stable(status_o))
    else $error("Result payload changed while stalled.");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> red_o == 8'd0 && green_o == 8'd0 &&
      blue_o == 8'd0 && alpha_o == 8'd0 && repeat_count_o == 8'd0 && !image_end_o)
    else $error("Error result carries pixel data.");

  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> repeat_count_o != 8'd0 && repeat_count_o <= 8'd128)
    else $error("Pixel repeat count out of range.");

endmodule

bind tga_pixel_stream_decoder_top tgapsd_checker u_tgapsd_checker (.*);

`default_nettype wire

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgapsd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int RANDOM_BYTES = 450;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFE0001;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [7:0]  red, green, blue, alpha, repeat_count;
  logic        image_end, status;

  tga_pixel_stream_decoder_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .alpha_o        (alpha),
    .repeat_count_o (repeat_count),
    .image_end_o    (image_end),
    .status_o       (status)
  );

  // Decoder shadow: configuration and stream state.
  pix_fmt_e    fmt = FMT_BGR;
  logic        rle = 1'b0;
  logic [31:0] total = 32'd1;
  logic        expect_hdr = 1'b0;
  logic [7:0]  run_left = '0;
  logic        run_rep = 1'b0;
  logic [1:0]  slot = '0;
  logic [23:0] pix_bytes = '0;
  logic [31:0] emitted = '0;
  logic        img_done = 1'b0;
  logic        err_sent = 1'b0;

  result_t pixel_q[$];

  int cycle_cnt = 0;
  int fail_count = 0;
  int used_bytes = 0;
  int n_pixels = 0;
  int n_errors = 0;
  int n_writes = 0;
  int burst_left = 1;
  bit hold_req = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic clear_decoder();
    expect_hdr = rle;
    run_left = '0;
    run_rep = 1'b0;
    slot = '0;
    pix_bytes = '0;
    emitted = '0;
    img_done = 1'b0;
    err_sent = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    result_t     r;
    logic [31:0] cnt;
    logic [31:0] left;
    int          need;
    logic [7:0]  a;
    logic [15:0] w;
    r = '0;
    a = 8'h00;
    if (fmt == FMT_RSVD || (fmt == FMT_555 && rle)) begin
      if (!err_sent) begin
        err_sent = 1'b1;
        r.status = 1'b1;
        pixel_q.push_back(r);
        used_bytes++;
      end
      return;
    end
    if (img_done || emitted >= total) begin
      img_done = 1'b1;
      return;
    end
    used_bytes++;
    if (rle && (expect_hdr || run_left == 8'd0)) begin
      left = total - emitted;
      if (b < 8'd128) begin
        cnt = b + 32'd1;
        run_rep = 1'b0;
      end else begin
        cnt = b - 32'd127;
        run_rep = 1'b1;
      end
      if (cnt > left) cnt = left;
      run_left = cnt[7:0];
      expect_hdr = 1'b0;
      slot = '0;
      pix_bytes = '0;
      return;
    end
    need = (fmt == FMT_555) ? 2 : ((fmt == FMT_BGR) ? 3 : 4);
    if (slot < 2'd3) pix_bytes = pix_bytes | (24'(b) << (8 * slot));
    else a = b;
    slot = slot + 2'd1;
    if (slot != 2'd0 && slot < need) return;
    slot = '0;
    if (fmt == FMT_555) begin
      w = pix_bytes[15:0];
      r.blue = {w[4:0], 3'b000};
      r.green = {w[9:5], 3'b000};
      r.red = {w[14:10], 3'b000};
    end else begin
      r.blue = pix_bytes[7:0];
      r.green = pix_bytes[15:8];
      r.red = pix_bytes[23:16];
      r.alpha = (fmt == FMT_BGRA) ? a : 8'h00;
    end
    pix_bytes = '0;
    r.repeat_count = 8'd1;
    if (rle) begin
      if (run_rep) begin
        r.repeat_count = run_left;
        run_left = '0;
      end else begin
        run_left = run_left - 8'd1;
      end
      if (run_left == 8'd0) expect_hdr = 1'b1;
    end
    emitted = emitted + r.repeat_count;
    r.image_end = (emitted >= total);
    if (r.image_end) img_done = 1'b1;
    pixel_q.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    data_byte <= b;
    if (!in_valid) in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_writes++;
    case (idx)
      REG_FORMAT: fmt = pix_fmt_e'(value[1:0]);
      REG_RLE:    rle = value[0];
      REG_TOTAL:  total = value;
      default:    return;
    endcase
    clear_decoder();
  endtask

  task automatic setup_image(input pix_fmt_e f, input logic r, input logic [31:0] t);
    write_reg(REG_FORMAT, 32'(f));
    write_reg(REG_RLE, 32'(r));
    write_reg(REG_TOTAL, t);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    result_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected result: red %0h green %0h blue %0h status %0b",
                 red, green, blue, status);
          fail_count++;
        end else begin
          e = pixel_q.pop_front();
          if (e.status) n_errors++;
          else n_pixels++;
          check_field("red", e.red, red);
          check_field("green", e.green, green);
          check_field("blue", e.blue, blue);
          check_field("alpha", e.alpha, alpha);
          check_field("repeat_count", e.repeat_count, repeat_count);
          check_field("image_end", 8'(e.image_end), 8'(image_end));
          check_field("status", 8'(e.status), 8'(status));
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end
      case ((cycle_cnt / 300) % 3)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (cycle_cnt % 5 < 2);
      endcase
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic test_reset_state();
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'hFF);
    push_byte(8'hAA);
  endtask

  task automatic test_raw_formats();
    setup_image(FMT_555, 1'b0, 32'd2);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h80);
    setup_image(FMT_BGRA, 1'b0, 32'd1);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    push_byte(8'hFF);
  endtask

  task automatic test_rle_runs();
    setup_image(FMT_BGR, 1'b1, 32'd3);
    push_byte(8'h81);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    push_byte(8'hFF);
    push_byte(8'hFE);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(8'h10);
  endtask

  task automatic test_unsupported();
    setup_image(FMT_RSVD, 1'b0, 32'd4);
    push_byte(8'h12);
    push_byte(8'h34);
    setup_image(FMT_555, 1'b1, 32'd4);
    push_byte(8'h00);
    push_byte(8'hFF);
  endtask

  task automatic test_zero_total();
    setup_image(FMT_BGR, 1'b0, 32'd0);
    push_byte(8'h55);
    push_byte(8'hAA);
  endtask

  task automatic test_unmapped_register();
    setup_image(FMT_BGR, 1'b0, 32'd4);
    push_byte(8'h5A);
    push_byte(8'hA5);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    push_byte(8'h3C);
  endtask

  task automatic test_max_total();
    setup_image(FMT_BGRA, 1'b1, TOTAL_MAX);
    push_byte(8'hFF);
    repeat (4) push_byte(8'($urandom));
    push_byte(8'h00);
    repeat (4) push_byte(8'($urandom));
  endtask

  task automatic test_backpressure();
    setup_image(FMT_BGR, 1'b0, 32'd30);
    hold_req = 1'b1;
    repeat (90) push_byte(8'($urandom));
  endtask

  task automatic test_random();
    int          start;
    int          phase_bytes;
    int          k;
    logic [31:0] t;
    logic [7:0]  b;
    start = used_bytes;
    while (used_bytes - start < RANDOM_BYTES) begin
      k = $urandom_range(0, 15);
      if (k == 0) t = 32'd1;
      else if (k == 1) t = TOTAL_MAX;
      else if (k == 2) t = ($urandom % TOTAL_MAX) + 32'd1;
      else t = $urandom_range(2, 40);
      k = $urandom_range(0, 9);
      setup_image(k < 3 ? FMT_555 : (k < 6 ? FMT_BGR : (k < 9 ? FMT_BGRA : FMT_RSVD)),
                  1'($urandom_range(0, 1)), t);
      phase_bytes = 0;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(10, 30)) push_byte(8'($urandom));
      end else begin
        while (!img_done && emitted < total && phase_bytes < 120 && !err_sent) begin
          if (rle && (expect_hdr || run_left == 8'd0)) begin
            k = $urandom_range(0, 9);
            if (k == 0) b = 8'($urandom);
            else if (k == 1) b = $urandom_range(0, 1) ? 8'h7F : 8'hFF;
            else if (k < 6) b = 8'($urandom_range(0, 5));
            else b = 8'($urandom_range(128, 134));
          end else begin
            b = 8'($urandom);
          end
          push_byte(b);
          phase_bytes++;
        end
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_raw_formats();
    test_rle_runs();
    test_unsupported();
    test_zero_total();
    test_unmapped_register();
    test_max_total();
    test_backpressure();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    $display("tb: %0d decoded bytes over %0d register writes; %0d pixel results and %0d",
             used_bytes, n_writes, n_pixels, n_errors);
    $display("tb: format error results compared, all formats with and without run-length coding");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
